// File: hdl/triangle_span_rasterizer_unit_defines.svh
// Assertion macros for the triangle span rasterizer unit.
// No dependencies; included by the checker file by its bare name.
`ifndef TRIANGLE_SPAN_RASTERIZER_UNIT_DEFINES_SVH
`define TRIANGLE_SPAN_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSRU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsru: same-cycle property violated");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSRU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsru: next-cycle property violated");

`endif

// File: hdl/tsru_pkg.sv
// Shared constants, types and sequencer states of the triangle span rasterizer.
// No dependencies; imported by every module of the block.
package tsru_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_ROWS   = 64;

  localparam int X_W        = 10;
  localparam int Y_W        = 7;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 9;

  localparam int WY_W       = Y_W + 1;
  localparam int ACC_W      = FRAC_BITS + X_W + 1;
  localparam int DX_W       = X_W + 1;
  localparam int DY_W       = Y_W;
  localparam int DEN_W      = DY_W + 1;
  localparam int CNT_W      = $clog2(ACC_W);
  localparam int C_W        = ACC_W + 1 - FRAC_BITS;

  localparam int NUM_VERT   = 3;
  localparam int PTR_W      = 2;
  localparam int REM_W      = 2;
  localparam int EDGES_INIT = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROW,
    ST_EDGE_CHK,
    ST_WALK,
    ST_DIV,
    ST_SWAP,
    ST_EMIT,
    ST_FINISH
  } tsru_state_e;

  typedef struct packed {
    logic push;
    logic flush;
  } span_ctrl_t;

  typedef struct packed {
    logic                   start;
    logic signed [DX_W-1:0] dx;
    logic [DY_W-1:0]        dy;
  } div_req_t;

endpackage

// File: hdl/triangle_span_rasterizer_unit.sv
// Top level of the triangle span rasterizer: edge-walk sequencer and edge state.
// Depends on tsru_pkg, tsru_div and tsru_span_out.
//
// Pulse start_i while busy_o is low to hand over one triangle (three integer
// vertices); busy_o rises on the next cycle and stays high until the triangle is
// finished. The block then emits one span per covered row, top to bottom, each
// on the span ports for exactly one cycle with span_strobe_o high; there is no
// backpressure, so the receiver must take every strobed transaction. The final
// transaction of a triangle carries last_span_o; a triangle that covers no
// visible row yields a single transaction with span_valid_o low and all fields
// zero. Spans on rows below zero or at or after row 64 are suppressed, left ends
// are clipped to column zero and both ends saturate at column 511. Each walked
// row passes through row check, chain swap and emit; a row that reloads an
// edge adds edge checks, a walk step per vertex stepped and a divide per edge
// slope in the single shared bit-serial divider, which produces one quotient
// bit per cycle; a triangle needs at most three slopes, and setup and finish
// add a state each. The last transaction is on the ports in the first cycle
// with busy_o low, and a new triangle may be started in that cycle.
module triangle_span_rasterizer_unit import tsru_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic signed [X_W-1:0] vert0_x_i,
  input  logic signed [Y_W-1:0] vert0_y_i,
  input  logic signed [X_W-1:0] vert1_x_i,
  input  logic signed [Y_W-1:0] vert1_y_i,
  input  logic signed [X_W-1:0] vert2_x_i,
  input  logic signed [Y_W-1:0] vert2_y_i,
  output logic                  span_strobe_o,
  output logic [ROW_W-1:0]      span_row_o,
  output logic [COL_W-1:0]      span_left_o,
  output logic [COL_W-1:0]      span_right_o,
  output logic                  span_valid_o,
  output logic                  last_span_o
);

  tsru_state_e state_q, state_d;

  // captured triangle
  logic signed [X_W-1:0]   vx_q [NUM_VERT];
  logic signed [X_W-1:0]   vx_d [NUM_VERT];
  logic signed [Y_W-1:0]   vy_q [NUM_VERT];
  logic signed [Y_W-1:0]   vy_d [NUM_VERT];
  logic signed [Y_W-1:0]   ymin_q, ymin_d;
  logic signed [Y_W-1:0]   ymax_q, ymax_d;

  // per-edge state, two active edges
  logic signed [ACC_W-1:0] acc_q [2];
  logic signed [ACC_W-1:0] acc_d [2];
  logic signed [ACC_W-1:0] step_q [2];
  logic signed [ACC_W-1:0] step_d [2];
  logic signed [Y_W-1:0]   end_row_q [2];
  logic signed [Y_W-1:0]   end_row_d [2];
  logic [PTR_W-1:0]        ptr_q [2];
  logic [PTR_W-1:0]        ptr_d [2];

  // walk control
  logic signed [WY_W-1:0]  y_q, y_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic                    edge_q, edge_d;
  logic                    left_q, left_d;
  logic [PTR_W-1:0]        walk_p_q, walk_p_d;
  logic signed [X_W-1:0]   walk_xs_q, walk_xs_d;

  // setup search
  logic signed [Y_W-1:0]   s_min, s_max;
  logic [PTR_W-1:0]        s_imin;

  // combinational helpers
  logic signed [Y_W-1:0]   end_sel;
  logic [PTR_W-1:0]        ptr_sel;
  logic                    ge0, ge1, ge_sel;
  logic                    reload_row;
  logic signed [X_W-1:0]   vx_p;
  logic signed [Y_W-1:0]   ty;
  logic signed [WY_W-1:0]  ty_w;
  logic signed [WY_W-1:0]  dy_full;
  logic                    walk_stop;
  logic                    walk_dead;
  logic [PTR_W-1:0]        p_next;
  logic signed [ACC_W-1:0] acc_l, acc_r;

  div_req_t                div_req;
  logic                    div_done;
  logic signed [ACC_W-1:0] div_quot;
  span_ctrl_t              span_ctrl;

  // topmost vertex, lowest index wins a tie
  always_comb begin
    s_min  = vy_q[0];
    s_max  = vy_q[0];
    s_imin = '0;
    if (vy_q[1] < s_min) begin
      s_min  = vy_q[1];
      s_imin = PTR_W'(1);
    end
    if (vy_q[2] < s_min) begin
      s_min  = vy_q[2];
      s_imin = PTR_W'(2);
    end
    if (vy_q[1] > s_max) begin
      s_max = vy_q[1];
    end
    if (vy_q[2] > s_max) begin
      s_max = vy_q[2];
    end
  end

  assign ge0        = (y_q >= end_row_q[0]);
  assign ge1        = (y_q >= end_row_q[1]);
  assign end_sel    = edge_q ? end_row_q[1] : end_row_q[0];
  assign ptr_sel    = edge_q ? ptr_q[1] : ptr_q[0];
  assign ge_sel     = (y_q >= end_sel);
  // the bottom row keeps the accumulated x as it stands; the top row always loads
  assign reload_row = (y_q < ymax_q) || (y_q == ymin_q);

  assign vx_p      = vx_q[walk_p_q];
  assign ty        = vy_q[walk_p_q];
  assign ty_w      = {ty[Y_W-1], ty};
  assign dy_full   = ty_w - y_q;
  assign walk_stop = (ty_w > y_q) || (rem_q == '0);
  // chain ran out of edges below the current row: the walk ends here
  assign walk_dead = (y_q >= ty_w);

  // edge 0 runs forward through the vertices, edge 1 backward
  always_comb begin
    if (edge_q) begin
      p_next = (walk_p_q == '0) ? PTR_W'(NUM_VERT - 1) : (walk_p_q - 1'b1);
    end else begin
      p_next = (walk_p_q == PTR_W'(NUM_VERT - 1)) ? '0 : (walk_p_q + 1'b1);
    end
  end

  assign acc_l = left_q ? acc_q[1] : acc_q[0];
  assign acc_r = left_q ? acc_q[0] : acc_q[1];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ST_ROW;
      end
      ST_ROW: begin
        state_d = (reload_row && (ge0 || ge1)) ? ST_EDGE_CHK : ST_SWAP;
      end
      ST_EDGE_CHK: begin
        priority if (ge_sel) begin
          state_d = ST_WALK;
        end else if (edge_q) begin
          state_d = ST_SWAP;
        end else begin
          state_d = ST_EDGE_CHK;
        end
      end
      ST_WALK: begin
        if (walk_stop) begin
          state_d = walk_dead ? ST_FINISH : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = edge_q ? ST_SWAP : ST_EDGE_CHK;
        end
      end
      ST_SWAP: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        state_d = (y_q >= ymax_q) ? ST_FINISH : ST_ROW;
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath updates and control outputs
  always_comb begin
    vx_d      = vx_q;
    vy_d      = vy_q;
    ymin_d    = ymin_q;
    ymax_d    = ymax_q;
    acc_d     = acc_q;
    step_d    = step_q;
    end_row_d = end_row_q;
    ptr_d     = ptr_q;
    y_d       = y_q;
    rem_d     = rem_q;
    edge_d    = edge_q;
    left_d    = left_q;
    walk_p_d  = walk_p_q;
    walk_xs_d = walk_xs_q;
    div_req   = '0;
    span_ctrl = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          vx_d[0] = vert0_x_i;
          vx_d[1] = vert1_x_i;
          vx_d[2] = vert2_x_i;
          vy_d[0] = vert0_y_i;
          vy_d[1] = vert1_y_i;
          vy_d[2] = vert2_y_i;
        end
      end
      ST_SETUP: begin
        ymin_d       = s_min;
        ymax_d       = s_max;
        ptr_d[0]     = s_imin;
        ptr_d[1]     = s_imin;
        end_row_d[0] = s_min;
        end_row_d[1] = s_min;
        acc_d[0]     = '0;
        acc_d[1]     = '0;
        step_d[0]    = '0;
        step_d[1]    = '0;
        rem_d        = REM_W'(EDGES_INIT);
        y_d          = {s_min[Y_W-1], s_min};
        left_d       = 1'b0;
        edge_d       = 1'b0;
      end
      ST_ROW: begin
        edge_d = 1'b0;
      end
      ST_EDGE_CHK: begin
        if (ge_sel) begin
          walk_p_d  = ptr_sel;
          walk_xs_d = '0;
        end else begin
          edge_d = 1'b1;
        end
      end
      ST_WALK: begin
        // advance one vertex per cycle until the chain's next end lies below or no edge is left
        priority if (!walk_stop) begin
          walk_xs_d = vx_p;
          walk_p_d  = p_next;
          rem_d     = rem_q - 1'b1;
        end else if (!walk_dead) begin
          end_row_d[edge_q] = ty;
          ptr_d[edge_q]     = walk_p_q;
          acc_d[edge_q]     = {walk_xs_q[X_W-1], walk_xs_q, {FRAC_BITS{1'b0}}};
          div_req.start     = 1'b1;
          div_req.dx        = {vx_p[X_W-1], vx_p} - {walk_xs_q[X_W-1], walk_xs_q};
          div_req.dy        = dy_full[DY_W-1:0];
        end else begin
          rem_d = rem_q;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          step_d[edge_q] = div_quot;
          edge_d         = 1'b1;
        end
      end
      ST_SWAP: begin
        // chains crossed: swap roles
        if (acc_l > acc_r) begin
          left_d = ~left_q;
        end
      end
      ST_EMIT: begin
        span_ctrl.push = 1'b1;
        acc_d[0]       = acc_q[0] + step_q[0];
        acc_d[1]       = acc_q[1] + step_q[1];
        y_d            = y_q + 1'b1;
      end
      ST_FINISH: begin
        span_ctrl.flush = 1'b1;
      end
      default: begin
        span_ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q      <= vx_d;
    vy_q      <= vy_d;
    ymin_q    <= ymin_d;
    ymax_q    <= ymax_d;
    acc_q     <= acc_d;
    step_q    <= step_d;
    end_row_q <= end_row_d;
    ptr_q     <= ptr_d;
    y_q       <= y_d;
    rem_q     <= rem_d;
    edge_q    <= edge_d;
    left_q    <= left_d;
    walk_p_q  <= walk_p_d;
    walk_xs_q <= walk_xs_d;
  end

  assign busy_o = (state_q != ST_IDLE);

  tsru_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  tsru_span_out u_span_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (span_ctrl),
    .row_i       (y_q),
    .acc_left_i  (acc_l),
    .acc_right_i (acc_r),
    .strobe_o    (span_strobe_o),
    .row_o       (span_row_o),
    .left_o      (span_left_o),
    .right_o     (span_right_o),
    .valid_o     (span_valid_o),
    .last_o      (last_span_o)
  );

endmodule

// File: hdl/tsru_div.sv
// Shared edge-step divider: rounded slope as one quotient bit per cycle.
// Depends on tsru_pkg.
module tsru_div import tsru_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_req_t                req_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] quot_o
);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [ACC_W-1:0] q_q, q_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;

  logic [DX_W-1:0]  dx_abs;
  logic [ACC_W-1:0] shifted;
  logic [ACC_W-1:0] dy_ext;
  logic [ACC_W-1:0] mag;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // numerator magnitude: |dx| * 2^(F+1) +/- dy, sign taken from dx
  always_comb begin
    dx_abs  = req_i.dx[DX_W-1] ? DX_W'(-req_i.dx) : DX_W'(req_i.dx);
    shifted = {dx_abs[DX_W-2:0], {(FRAC_BITS + 1){1'b0}}};
    dy_ext  = ACC_W'(req_i.dy);
    mag     = req_i.dx[DX_W-1] ? (shifted - dy_ext) : (shifted + dy_ext);
  end

  assign trial = {rem_q, q_q[ACC_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    q_d    = q_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      neg_d = req_i.dx[DX_W-1];
      q_d   = mag;
      rem_d = '0;
      den_d = {req_i.dy, 1'b0};
    end else if (run_q) begin
      q_d   = {q_q[ACC_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ACC_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    q_q   <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~q_q + 1'b1) : q_q;

endmodule

// File: hdl/tsru_span_out.sv
// Span end rounding, clipping, one-deep holdback and the result register.
// Depends on tsru_pkg.
module tsru_span_out import tsru_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  span_ctrl_t              ctrl_i,
  input  logic signed [WY_W-1:0]  row_i,
  input  logic signed [ACC_W-1:0] acc_left_i,
  input  logic signed [ACC_W-1:0] acc_right_i,
  output logic                    strobe_o,
  output logic [ROW_W-1:0]        row_o,
  output logic [COL_W-1:0]        left_o,
  output logic [COL_W-1:0]        right_o,
  output logic                    valid_o,
  output logic                    last_o
);

  function automatic logic signed [C_W-1:0] round_col(logic signed [ACC_W-1:0] x);
    logic [ACC_W:0] s;
    s = {x[ACC_W-1], x} +
        {{(ACC_W - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    return s[ACC_W:FRAC_BITS];
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(logic signed [C_W-1:0] c);
    logic [COL_W-1:0] r;
    if (c[C_W-1]) begin
      r = '0;
    end else if (|c[C_W-2:COL_W]) begin
      r = {COL_W{1'b1}};
    end else begin
      r = c[COL_W-1:0];
    end
    return r;
  endfunction

  logic signed [C_W-1:0] c_left, c_right;
  logic                  take;

  logic             pend_valid_q, pend_valid_d;
  logic [ROW_W-1:0] pend_row_q, pend_row_d;
  logic [COL_W-1:0] pend_left_q, pend_left_d;
  logic [COL_W-1:0] pend_right_q, pend_right_d;

  logic             strobe_q, strobe_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [COL_W-1:0] out_left_q, out_left_d;
  logic [COL_W-1:0] out_right_q, out_right_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;

  assign c_left  = round_col(acc_left_i);
  assign c_right = round_col(acc_right_i);
  // drop rows off the top or bottom, and spans lying fully left of column zero
  assign take    = (int'(row_i) >= 0) && (int'(row_i) < MAX_ROWS) && !c_right[C_W-1];

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_row_d   = pend_row_q;
    pend_left_d  = pend_left_q;
    pend_right_d = pend_right_q;
    strobe_d     = 1'b0;
    out_row_d    = out_row_q;
    out_left_d   = out_left_q;
    out_right_d  = out_right_q;
    out_valid_d  = out_valid_q;
    out_last_d   = out_last_q;
    if (ctrl_i.flush) begin
      strobe_d     = 1'b1;
      out_last_d   = 1'b1;
      out_valid_d  = pend_valid_q;
      out_row_d    = pend_valid_q ? pend_row_q : '0;
      out_left_d   = pend_valid_q ? pend_left_q : '0;
      out_right_d  = pend_valid_q ? pend_right_q : '0;
      pend_valid_d = 1'b0;
    end else if (ctrl_i.push && take) begin
      if (pend_valid_q) begin
        strobe_d    = 1'b1;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
        out_row_d   = pend_row_q;
        out_left_d  = pend_left_q;
        out_right_d = pend_right_q;
      end
      pend_valid_d = 1'b1;
      pend_row_d   = row_i[ROW_W-1:0];
      pend_left_d  = clamp_col(c_left);
      pend_right_d = clamp_col(c_right);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      strobe_q     <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_row_q   <= pend_row_d;
    pend_left_q  <= pend_left_d;
    pend_right_q <= pend_right_d;
    out_row_q    <= out_row_d;
    out_left_q   <= out_left_d;
    out_right_q  <= out_right_d;
    out_valid_q  <= out_valid_d;
    out_last_q   <= out_last_d;
  end

  assign strobe_o = strobe_q;
  assign row_o    = out_row_q;
  assign left_o   = out_left_q;
  assign right_o  = out_right_q;
  assign valid_o  = out_valid_q;
  assign last_o   = out_last_q;

endmodule

// File: hdl/tsru_checker.sv
// Port-level checker for the triangle span rasterizer, bound to the top level.
// Depends on tsru_pkg and triangle_span_rasterizer_unit_defines.svh.
`include "triangle_span_rasterizer_unit_defines.svh"

module tsru_checker import tsru_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             span_strobe_o,
  input logic [COL_W-1:0] span_left_o,
  input logic [COL_W-1:0] span_right_o,
  input logic             span_valid_o,
  input logic             last_span_o
);

  // an accepted triangle keeps the block busy
  `TSRU_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  // intermediate spans come out mid-walk, the final one once the block is free
  `TSRU_ASSERT_SAME(a_mid_busy, span_strobe_o && !last_span_o, busy_o)
  `TSRU_ASSERT_SAME(a_last_idle, span_strobe_o && last_span_o, !busy_o)
  // nothing follows the closing transaction directly
  `TSRU_ASSERT_NEXT(a_last_gap, span_strobe_o && last_span_o, !span_strobe_o)
  // chains are ordered, so a span never runs backwards
  `TSRU_ASSERT_SAME(a_span_order, span_strobe_o && span_valid_o,
                    span_left_o <= span_right_o)

endmodule

bind triangle_span_rasterizer_unit tsru_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .span_strobe_o (span_strobe_o),
  .span_left_o   (span_left_o),
  .span_right_o  (span_right_o),
  .span_valid_o  (span_valid_o),
  .last_span_o   (last_span_o)
);

// File: tb/tb_triangle_span_rasterizer_unit.sv
// Self-checking testbench for triangle_span_rasterizer_unit: a directed set of
// corner-case triangles followed by random ones, predicted by an in-bench span walker.
// Depends on tsru_pkg and the RTL of triangle_span_rasterizer_unit only.
`timescale 1ns / 1ps

module tb_triangle_span_rasterizer_unit;
  import tsru_pkg::*;

  // One triangle as handed to the block; drain makes the driver hold it back
  // until every span of the earlier triangles has come out.
  typedef struct {
    logic signed [X_W-1:0] x[3];
    logic signed [Y_W-1:0] y[3];
    bit                    drain;
  } triangle_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] left_col;
    logic [COL_W-1:0] right_col;
    logic             valid;
    logic             last;
  } span_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  start_i   = 1'b0;
  logic                  busy_o;
  logic signed [X_W-1:0] vert0_x_i = '0;
  logic signed [Y_W-1:0] vert0_y_i = '0;
  logic signed [X_W-1:0] vert1_x_i = '0;
  logic signed [Y_W-1:0] vert1_y_i = '0;
  logic signed [X_W-1:0] vert2_x_i = '0;
  logic signed [Y_W-1:0] vert2_y_i = '0;
  logic                  span_strobe_o;
  logic [ROW_W-1:0]      span_row_o;
  logic [COL_W-1:0]      span_left_o;
  logic [COL_W-1:0]      span_right_o;
  logic                  span_valid_o;
  logic                  last_span_o;

  triangle_span_rasterizer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .vert0_x_i     (vert0_x_i),
    .vert0_y_i     (vert0_y_i),
    .vert1_x_i     (vert1_x_i),
    .vert1_y_i     (vert1_y_i),
    .vert2_x_i     (vert2_x_i),
    .vert2_y_i     (vert2_y_i),
    .span_strobe_o (span_strobe_o),
    .span_row_o    (span_row_o),
    .span_left_o   (span_left_o),
    .span_right_o  (span_right_o),
    .span_valid_o  (span_valid_o),
    .last_span_o   (last_span_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Triangles waiting for the driver, and spans waiting for the block.
  triangle_t pending_triangles[$];
  span_t     expected_spans[$];

  int triangles_total = 0;
  int triangles_taken = 0;
  int spans_checked   = 0;
  int empty_checked   = 0;
  int fail_count      = 0;

  // Edge-walk state of the span predictor, reloaded for every triangle.
  longint      chain_x[2];
  longint      chain_slope[2];
  longint      chain_stop_row[2];
  int unsigned chain_vertex[2];
  longint      walk_row;
  int unsigned edges_left;

  // Round a fixed-point column to nearest; the bias keeps the shift on a
  // non-negative value so it acts as a floor.
  function automatic longint nearest_column(input longint xf);
    longint v;
    v = xf + (longint'(1) << (FRAC_BITS - 1)) + (longint'(1) << (FRAC_BITS + 12));
    if (v < 0) v = 0;
    return (v >>> FRAC_BITS) - (longint'(1) << 12);
  endfunction

  function automatic longint clip_column(input longint c);
    if (c < 0) return 0;
    if (c > 511) return 511;
    return c;
  endfunction

  // Append one span to the tail of the expected list.
  function automatic void add_expected(input span_t s);
    expected_spans.insert(expected_spans.size(), s);
  endfunction

  // Walk one triangle from its top row down and queue the spans it must yield.
  function automatic void predict_spans(input triangle_t t);
    longint      vx[3];
    longint      vy[3];
    int unsigned walk_dir[2];
    int unsigned top_idx, lane_lo, lane_hi, k, p;
    longint      ymin, ymax, y, xs, ty, num, den, c_lo, c_hi;
    int          n;
    bit          stuck;
    span_t       s;
    walk_dir[0] = 1;
    walk_dir[1] = 2;
    for (k = 0; k < 3; k++) begin
      vx[k] = longint'(t.x[k]);
      vy[k] = longint'(t.y[k]);
    end
    // Lowest numbered vertex wins a tie for the top row.
    top_idx = 0;
    ymin    = vy[0];
    ymax    = vy[0];
    for (k = 0; k < 3; k++) begin
      if (vy[k] < ymin) begin
        ymin    = vy[k];
        top_idx = k;
      end
      if (vy[k] > ymax) ymax = vy[k];
    end
    for (k = 0; k < 2; k++) begin
      chain_vertex[k]   = top_idx;
      chain_stop_row[k] = ymin;
      chain_x[k]        = 0;
      chain_slope[k]    = 0;
    end
    edges_left = 3;
    lane_lo    = 0;
    lane_hi    = 1;
    n          = 0;
    stuck      = 1'b0;
    y          = ymin;
    forever begin
      // Reload expired chains, except on the bottom row unless it is also the top row.
      if (y < ymax || y == ymin) begin
        for (k = 0; k < 2 && !stuck; k++) begin
          if (y >= chain_stop_row[k]) begin
            p  = chain_vertex[k] % 3;
            xs = 0;
            ty = 0;
            forever begin
              ty = vy[p];
              if (ty > y || edges_left == 0) break;
              xs = vx[p];
              p  = (p + walk_dir[k]) % 3;
              edges_left--;
            end
            // No edge left to continue this chain: stop the walk here.
            if (y >= ty) begin
              stuck = 1'b1;
              break;
            end
            chain_stop_row[k] = ty;
            num = (vx[p] - xs) * (longint'(1) << FRAC_BITS) * 2 + (ty - y);
            den = 2 * (ty - y);
            chain_slope[k] = num / den;
            chain_x[k]     = xs * (longint'(1) << FRAC_BITS);
            chain_vertex[k] = p;
          end
        end
      end
      if (stuck) break;
      // Swap chain roles once they cross.
      if (chain_x[lane_lo] > chain_x[lane_hi]) begin
        lane_lo ^= 1;
        lane_hi ^= 1;
      end
      if (y >= 0 && y < MAX_ROWS && n < MAX_ROWS) begin
        c_lo = nearest_column(chain_x[lane_lo]);
        c_hi = nearest_column(chain_x[lane_hi]);
        if (c_hi >= 0) begin
          s.row       = y[ROW_W-1:0];
          s.left_col  = COL_W'(clip_column(c_lo));
          s.right_col = COL_W'(clip_column(c_hi));
          s.valid     = 1'b1;
          s.last      = 1'b0;
          add_expected(s);
          n++;
        end
      end
      chain_x[lane_lo] += chain_slope[lane_lo];
      chain_x[lane_hi] += chain_slope[lane_hi];
      y++;
      if (y > ymax) break;
    end
    walk_row = y;
    if (n == 0) begin
      s = '0;
      s.last = 1'b1;
      add_expected(s);
    end else begin
      expected_spans[expected_spans.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void queue_triangle(input int x0, input int y0, input int x1,
                                         input int y1, input int x2, input int y2,
                                         input bit drain);
    triangle_t t;
    t.x[0]  = X_W'(x0);
    t.y[0]  = Y_W'(y0);
    t.x[1]  = X_W'(x1);
    t.y[1]  = Y_W'(y1);
    t.x[2]  = X_W'(x2);
    t.y[2]  = Y_W'(y2);
    t.drain = drain;
    pending_triangles.insert(pending_triangles.size(), t);
  endfunction

  // Driver. Holds the triangle on offer until the block takes it, drops start
  // in random bursts (also while busy, so that the offer lands on every phase of
  // the walk), but only while at least twenty more triangles wait in the queue.
  triangle_t in_flight;
  bit        holding   = 1'b0;
  int        idle_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i    <= 1'b0;
      vert0_x_i  <= '0;
      vert0_y_i  <= '0;
      vert1_x_i  <= '0;
      vert1_y_i  <= '0;
      vert2_x_i  <= '0;
      vert2_y_i  <= '0;
      holding    = 1'b0;
      idle_left  = 0;
      for (int k = 0; k < 2; k++) begin
        chain_x[k]        = 0;
        chain_slope[k]    = 0;
        chain_stop_row[k] = 0;
        chain_vertex[k]   = 0;
      end
      walk_row   = 0;
      edges_left = 3;
    end else begin
      // A transaction completes on this edge: predict its spans now.
      if (start_i && !busy_o) begin
        predict_spans(in_flight);
        triangles_taken++;
        holding = 1'b0;
      end
      // Fetch the next triangle, unless it must wait for the pipeline to drain.
      if (!holding && pending_triangles.size() != 0 &&
          !(pending_triangles[0].drain && expected_spans.size() != 0)) begin
        in_flight = pending_triangles.pop_front();
        holding   = 1'b1;
        vert0_x_i <= in_flight.x[0];
        vert0_y_i <= in_flight.y[0];
        vert1_x_i <= in_flight.x[1];
        vert1_y_i <= in_flight.y[1];
        vert2_x_i <= in_flight.x[2];
        vert2_y_i <= in_flight.y[2];
      end
      if (idle_left > 0) begin
        idle_left--;
        start_i <= 1'b0;
      end else if (holding && pending_triangles.size() >= 20 &&
                   $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(0, 14);
        start_i <= 1'b0;
      end else begin
        start_i <= holding;
      end
    end
  end

  // Monitor: every strobed transaction must match the oldest expected span.
  span_t want;

  always @(posedge clk_i) begin
    if (rst_ni && span_strobe_o) begin
      if (expected_spans.size() == 0) begin
        $error("unexpected span transaction: row %0d left %0d right %0d valid %0b",
               span_row_o, span_left_o, span_right_o, span_valid_o);
        fail_count++;
      end else begin
        want = expected_spans.pop_front();
        if (span_row_o !== want.row) begin
          $error("span_row: expected %0d, actual %0d", want.row, span_row_o);
          fail_count++;
        end
        if (span_left_o !== want.left_col) begin
          $error("span_left: expected %0d, actual %0d", want.left_col, span_left_o);
          fail_count++;
        end
        if (span_right_o !== want.right_col) begin
          $error("span_right: expected %0d, actual %0d", want.right_col, span_right_o);
          fail_count++;
        end
        if (span_valid_o !== want.valid) begin
          $error("span_valid: expected %0b, actual %0b", want.valid, span_valid_o);
          fail_count++;
        end
        if (last_span_o !== want.last) begin
          $error("last_span: expected %0b, actual %0b", want.last, last_span_o);
          fail_count++;
        end
        if (want.valid) spans_checked++;
        else empty_checked++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int xs[3];
    int ys[3];
    int kind, bx, by;
    // Directed: field extremes, the no-span cases, top ties, crossing chains.
    queue_triangle(0, 0, 10, 0, 0, 10, 1'b0);
    queue_triangle(-5, 20, 100, 20, 300, 20, 1'b0);        // flat: no span
    queue_triangle(-512, 0, -300, 30, -400, 63, 1'b0);     // off screen left
    queue_triangle(0, -64, 50, -10, 100, -1, 1'b0);        // every row above row zero
    queue_triangle(7, 7, 7, 7, 7, 7, 1'b0);                // single point
    queue_triangle(-512, -64, 511, 63, -512, 63, 1'b1);    // full height, clip and saturate
    queue_triangle(511, -64, -512, 63, 511, 63, 1'b0);
    queue_triangle(10, 5, 60, 5, 30, 40, 1'b0);            // top tie, vertices 0 and 1
    queue_triangle(30, 40, 10, 5, 60, 5, 1'b0);            // top tie, vertices 1 and 2
    queue_triangle(60, 5, 30, 40, 10, 5, 1'b0);            // top tie, vertices 0 and 2
    queue_triangle(30, 5, 10, 40, 60, 40, 1'b0);           // flat bottom
    queue_triangle(100, 0, 0, 30, 20, 60, 1'b0);
    queue_triangle(0, 0, 200, 10, -100, 60, 1'b0);         // chains cross
    queue_triangle(5, 0, 0, 3, -7, 7, 1'b0);               // odd negative slopes
    queue_triangle(0, 0, 10, 10, 20, 20, 1'b0);            // collinear
    queue_triangle(5, 10, 20, 11, 40, 10, 1'b0);           // two rows tall
    queue_triangle(500, 0, 511, 30, 505, 50, 1'b0);
    queue_triangle(-50, 10, 30, 10, -50, 40, 1'b0);        // left end below zero
    queue_triangle(-3, -1, 3, 1, 0, 1, 1'b0);
    queue_triangle(-512, 0, 511, 0, 0, 63, 1'b1);
    queue_triangle(511, 63, 0, -64, -512, 63, 1'b0);
    // Random: on-screen triangles half the time, else full range, small or degenerate.
    for (int n = 0; n < 80; n++) begin
      kind = $urandom_range(0, 19);
      for (int k = 0; k < 3; k++) begin
        if (kind < 10) begin
          xs[k] = $urandom_range(0, 607) - 96;
          ys[k] = $urandom_range(0, 71) - 8;
        end else begin
          xs[k] = $urandom_range(0, 1023) - 512;
          ys[k] = $urandom_range(0, 127) - 64;
        end
      end
      if (kind >= 15 && kind < 18) begin
        bx = $urandom_range(0, 519) - 20;
        by = $urandom_range(0, 55) - 4;
        for (int k = 0; k < 3; k++) begin
          xs[k] = bx + $urandom_range(0, 12);
          ys[k] = by + $urandom_range(0, 12);
        end
      end else if (kind >= 18) begin
        // Share a row between two vertices to hit ties and flat edges.
        ys[$urandom_range(1, 2)] = ys[0];
      end
      queue_triangle(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], n % 25 == 12);
    end
    triangles_total = pending_triangles.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (triangles_taken < triangles_total) @(posedge clk_i);
    while (expected_spans.size() != 0) @(posedge clk_i);
    // Leave room for any stray transaction after the last span.
    repeat (200) @(posedge clk_i);

    $display("Covered %0d triangles: %0d spans and %0d empty-triangle results checked.",
             triangles_total, spans_checked, empty_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #4_000_000;
    $display("Timeout: %0d of %0d triangles taken, %0d spans outstanding.",
             triangles_taken, triangles_total, expected_spans.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tsru_pkg.sv
hdl/tsru_div.sv
hdl/tsru_span_out.sv
hdl/triangle_span_rasterizer_unit.sv
hdl/tsru_checker.sv
tb/tb_triangle_span_rasterizer_unit.sv
